// ----- hdl/rpc_pkg.sv -----
// rpc_pkg: shared types and constants of the recirculation pump controller.
// Used by rpc_sec_div, recirc_pump_controller and rpc_checker. No dependencies.

package rpc_pkg;

  typedef enum logic [2:0] {
    REG_PUMP_TIMEOUT  = 3'd0,
    REG_VALVE_TIMEOUT = 3'd1,
    REG_YIELD_TIMEOUT = 3'd2,
    REG_READ_INTERVAL = 3'd3,
    REG_STOP_TEMP     = 3'd4,
    REG_IDLE_TIMEOUT  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_FULL   = 2'd2
  } loop_mode_t;

  typedef enum logic [1:0] {
    SLEEP_MIN   = 2'd0,
    SLEEP_MID   = 2'd1,
    SLEEP_MAX   = 2'd2
  } sleep_t;

  localparam int FLAG_FULL      = 0;
  localparam int FLAG_HOLDOFF   = 1;
  localparam int FLAG_FIRST_RUN = 2;

  localparam int MSEC_PER_SEC = 1000;
  localparam int DIV_SHIFT    = 26;
  localparam int DIV_MULT     = ((1 << DIV_SHIFT) + MSEC_PER_SEC - 1) / MSEC_PER_SEC;
  localparam int SECS_W       = 7;

  localparam logic [15:0] PUMP_TIMER_RST = 16'd10;
  localparam logic [15:0] INIT_YIELD     = 16'd10;
  localparam logic [15:0] BLINK_RELOAD   = 16'd5;
  localparam logic [15:0] IDLE_MIN       = 16'd600;
  localparam logic [17:0] REFRESH_YIELD  = 18'd180;
  localparam logic signed [15:0] TEMP_HOLD_MAX = 16'sd1000;

  // result word, lowest bit is pump_on
  typedef struct packed {
    logic [2:0]  pad;
    logic        temps_latched;
    logic [15:0] pump_seconds_left;
    logic [2:0]  status_flags;
    logic [1:0]  sleep_class;
    logic        blink_idle;
    logic        blink_yield;
    logic        blink_valve;
    logic        blink_pump;
    logic [1:0]  loop_mode;
    logic        pump_on;
  } out_word_t;

endpackage

// ----- hdl/rpc_sec_div.sv -----
// rpc_sec_div: whole seconds in a 16-bit millisecond difference.
// Reciprocal multiply, exact over the full 16-bit range. Uses rpc_pkg.

module rpc_sec_div (
  input  logic [15:0]                msec_diff,
  output logic [rpc_pkg::SECS_W-1:0] secs
);

  localparam int PROD_W = 16 + 17;

  logic [PROD_W-1:0] prod;

  assign prod = {17'd0, msec_diff} * PROD_W'(rpc_pkg::DIV_MULT);
  assign secs = prod[rpc_pkg::DIV_SHIFT +: rpc_pkg::SECS_W];

endmodule

// ----- hdl/recirc_pump_controller.sv -----
// recirc_pump_controller: hot-water recirculation pump controller, top level.
// Each round word moves from the input register through the round logic into
// the result register, both one deep. Throughput: one control round per cycle
// unless a full result register is stalled by out_tready low.
// Reset (rst_n low, synchronous): registers to their defaults, pump timer 10,
// initial run flag set, both stages empty. Depends on rpc_pkg, rpc_sec_div.

module recirc_pump_controller #(
  parameter int SENSORS        = 4,
  parameter int ADC_FULL_SCALE = 4095
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // clock_msec[31:0], flow_level[43:32], sensor_count[46:44],
  // temp_a[62:47], temp_b[78:63], temp_c[94:79], temp_d[110:95], zero[111]
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pump_on[0], loop_mode[2:1], blink_pump[3], blink_valve[4], blink_yield[5],
  // blink_idle[6], sleep_class[8:7], status_flags[11:9],
  // pump_seconds_left[27:12], temps_latched[28], zero[31:29]
  output logic [31:0]  out_tdata,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  localparam int NUM_TEMP_IN = 4;
  localparam int NLAT  = (SENSORS < NUM_TEMP_IN) ? SENSORS : NUM_TEMP_IN;
  localparam int CNT_W = $clog2(NLAT + 1);
  localparam logic [16:0] TH_ANY = 17'(ADC_FULL_SCALE * 90 / 100);
  localparam logic [16:0] TH_VER = 17'(ADC_FULL_SCALE * 50 / 100);

  // configuration
  logic [10:0] pump_to_r, yield_to_r;
  logic [8:0]  valve_to_r;
  logic [15:0] read_iv_r, idle_to_r;
  logic [9:0]  stop_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pump_to_r  <= 11'd180;
      valve_to_r <= 9'd20;
      yield_to_r <= 11'd300;
      read_iv_r  <= 16'd10;
      stop_t_r   <= 10'd420;
      idle_to_r  <= 16'd0;
    end else if (cfg_wr_en) begin
      case (rpc_pkg::reg_idx_t'(cfg_index))
        rpc_pkg::REG_PUMP_TIMEOUT:  pump_to_r  <= cfg_wdata[10:0];
        rpc_pkg::REG_VALVE_TIMEOUT: valve_to_r <= cfg_wdata[8:0];
        rpc_pkg::REG_YIELD_TIMEOUT: yield_to_r <= cfg_wdata[10:0];
        rpc_pkg::REG_READ_INTERVAL: read_iv_r  <= cfg_wdata;
        rpc_pkg::REG_STOP_TEMP:     stop_t_r   <= cfg_wdata[9:0];
        rpc_pkg::REG_IDLE_TIMEOUT:  idle_to_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage
  logic         in_v_r;
  logic [111:0] in_data_r;
  logic         out_v_r;
  rpc_pkg::out_word_t out_r, out_nxt;
  logic         adv;

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
  end

  // round state
  logic [15:0] last_msec_r, last_msec_nxt;
  logic [15:0] pump_tm_r, valve_tm_r, yield_tm_r, read_tm_r, blink_tm_r, idle_tm_r;
  logic [15:0] pump_tm_nxt, valve_tm_nxt, yield_tm_nxt, read_tm_nxt;
  logic [15:0] blink_tm_nxt, idle_tm_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic        running_r, running_nxt;
  logic signed [15:0] temps_r [NLAT];
  logic signed [15:0] temps_nxt [NLAT];
  logic [CNT_W-1:0]   lat_cnt_r, lat_cnt_nxt;

  logic [31:0] clk_in;
  logic [11:0] flow_in;
  logic [2:0]  cnt_in;
  logic signed [15:0] temp_in [NUM_TEMP_IN];
  logic [rpc_pkg::SECS_W-1:0] secs;

  assign clk_in  = in_data_r[31:0];
  assign flow_in = in_data_r[43:32];
  assign cnt_in  = in_data_r[46:44];
  always_comb begin
    for (int i = 0; i < NUM_TEMP_IN; i++) begin
      temp_in[i] = $signed(in_data_r[47 + 16 * i +: 16]);
    end
  end

  rpc_sec_div u_div (
    .msec_diff (clk_in[15:0] - last_msec_r),
    .secs      (secs)
  );

  function automatic logic [15:0] dec_sat(input logic [15:0] v,
                                          input logic [rpc_pkg::SECS_W-1:0] by);
    logic [15:0] by16;
    by16 = {{(16 - rpc_pkg::SECS_W){1'b0}}, by};
    return (v > by16) ? (v - by16) : 16'd0;
  endfunction

  always_comb begin
    logic use_any, use_ver, latch, hold, idle_on, b_yield, b_idle;
    logic [1:0] sleep;
    logic [1:0] mode;
    logic [CNT_W-1:0] n;

    last_msec_nxt = last_msec_r;
    pump_tm_nxt   = pump_tm_r;
    valve_tm_nxt  = valve_tm_r;
    yield_tm_nxt  = yield_tm_r;
    read_tm_nxt   = read_tm_r;
    blink_tm_nxt  = blink_tm_r;
    idle_tm_nxt   = idle_tm_r;
    flags_nxt     = flags_r;
    running_nxt   = running_r;
    temps_nxt     = temps_r;
    lat_cnt_nxt   = lat_cnt_r;
    b_yield       = 1'b0;
    b_idle        = 1'b0;
    sleep         = rpc_pkg::SLEEP_MIN;
    hold          = 1'b0;
    idle_on       = idle_to_r >= rpc_pkg::IDLE_MIN;

    if (secs != '0) begin
      last_msec_nxt = clk_in[15:0];
      pump_tm_nxt   = dec_sat(pump_tm_r, secs);
      valve_tm_nxt  = dec_sat(valve_tm_r, secs);
      yield_tm_nxt  = dec_sat(yield_tm_r, secs);
      read_tm_nxt   = dec_sat(read_tm_r, secs);
      blink_tm_nxt  = dec_sat(blink_tm_r, secs);
      if (idle_on) idle_tm_nxt = dec_sat(idle_tm_r, secs);
    end

    latch = (read_iv_r != 16'd0) && (read_tm_nxt == 16'd0);
    n = (32'(cnt_in) > NLAT) ? CNT_W'(NLAT) : CNT_W'(cnt_in);
    if (latch) begin
      read_tm_nxt = read_iv_r;
      for (int i = 0; i < NLAT; i++) begin
        if (CNT_W'(i) < n) temps_nxt[i] = temp_in[i];
      end
      lat_cnt_nxt = n;
    end

    use_any = {5'd0, flow_in} <= TH_ANY;
    use_ver = use_any && ({5'd0, flow_in} < TH_VER);

    if (use_ver) flags_nxt[rpc_pkg::FLAG_FULL] = 1'b1;

    if (pump_tm_nxt == 16'd0 && !flags_nxt[rpc_pkg::FLAG_FIRST_RUN] &&
        !flags_nxt[rpc_pkg::FLAG_HOLDOFF] && use_any) begin
      pump_tm_nxt = {5'd0, pump_to_r};
    end

    if (read_iv_r != 16'd0 && stop_t_r != 10'd0 && pump_tm_nxt != 16'd0) begin
      for (int i = 0; i < NLAT; i++) begin
        if (CNT_W'(i) < lat_cnt_nxt && temps_nxt[i] < rpc_pkg::TEMP_HOLD_MAX &&
            temps_nxt[i] < $signed({6'd0, stop_t_r})) begin
          hold = 1'b1;
        end
      end
      if (!hold) pump_tm_nxt = 16'd0;
    end

    if (valve_tm_nxt == 16'd0) mode = rpc_pkg::MODE_IDLE;
    else if (flags_nxt[rpc_pkg::FLAG_FULL]) mode = rpc_pkg::MODE_FULL;
    else mode = rpc_pkg::MODE_NORMAL;
    out_nxt.blink_pump  = pump_tm_nxt != 16'd0;
    out_nxt.blink_valve = valve_tm_nxt != 16'd0;

    if (pump_tm_nxt != 16'd0) begin
      if (!running_r) begin
        running_nxt = 1'b1;
        flags_nxt[rpc_pkg::FLAG_HOLDOFF] = 1'b1;
        yield_tm_nxt = {5'd0, yield_to_r};
      end
    end else if (running_r) begin
      running_nxt = 1'b0;
      flags_nxt[rpc_pkg::FLAG_FULL]    = 1'b0;
      flags_nxt[rpc_pkg::FLAG_HOLDOFF] = 1'b1;
      valve_tm_nxt = {7'd0, valve_to_r};
      yield_tm_nxt = {5'd0, yield_to_r};
      if (flags_nxt[rpc_pkg::FLAG_FIRST_RUN]) begin
        flags_nxt[rpc_pkg::FLAG_FIRST_RUN] = 1'b0;
        yield_tm_nxt = rpc_pkg::INIT_YIELD;
      end
      if (idle_on) idle_tm_nxt = idle_to_r;
    end else begin
      if (yield_tm_nxt == 16'd0) flags_nxt[rpc_pkg::FLAG_HOLDOFF] = 1'b0;
      if (flags_nxt[rpc_pkg::FLAG_HOLDOFF]) begin
        b_yield = 1'b1;
        // refresh only early in the yield period
        if (yield_tm_nxt < {5'd0, yield_to_r} &&
            $signed({2'd0, yield_tm_nxt}) >
            $signed({7'd0, yield_to_r}) - $signed(rpc_pkg::REFRESH_YIELD) &&
            use_any) begin
          yield_tm_nxt = {5'd0, yield_to_r};
        end
        sleep = rpc_pkg::SLEEP_MID;
      end else begin
        if (blink_tm_nxt == 16'd0) begin
          b_idle = 1'b1;
          blink_tm_nxt = rpc_pkg::BLINK_RELOAD;
        end
        sleep = rpc_pkg::SLEEP_MAX;
      end
    end

    out_nxt.pad               = 3'd0;
    out_nxt.temps_latched     = latch;
    out_nxt.pump_seconds_left = pump_tm_nxt;
    out_nxt.status_flags      = flags_nxt;
    out_nxt.sleep_class       = sleep;
    out_nxt.blink_idle        = b_idle;
    out_nxt.blink_yield       = b_yield;
    out_nxt.loop_mode         = mode;
    out_nxt.pump_on           = running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_msec_r <= 16'd0;
      pump_tm_r   <= rpc_pkg::PUMP_TIMER_RST;
      valve_tm_r  <= 16'd0;
      yield_tm_r  <= 16'd0;
      read_tm_r   <= 16'd0;
      blink_tm_r  <= 16'd0;
      idle_tm_r   <= 16'd0;
      flags_r     <= 3'(1 << rpc_pkg::FLAG_FIRST_RUN);
      running_r   <= 1'b0;
      lat_cnt_r   <= '0;
      for (int i = 0; i < NLAT; i++) temps_r[i] <= 16'sd0;
    end else if (adv) begin
      last_msec_r <= last_msec_nxt;
      pump_tm_r   <= pump_tm_nxt;
      valve_tm_r  <= valve_tm_nxt;
      yield_tm_r  <= yield_tm_nxt;
      read_tm_r   <= read_tm_nxt;
      blink_tm_r  <= blink_tm_nxt;
      idle_tm_r   <= idle_tm_nxt;
      flags_r     <= flags_nxt;
      running_r   <= running_nxt;
      lat_cnt_r   <= lat_cnt_nxt;
      temps_r     <= temps_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= out_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

endmodule

// ----- hdl/rpc_checker.sv -----
// rpc_checker: port-level assertions for recirc_pump_controller, and its bind.
// Depends on rpc_pkg for the result word layout.

module rpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  rpc_pkg::out_word_t w;
  assign w = out_tdata;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_pump_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (w.pump_on == (w.pump_seconds_left != 16'd0)) &&
                   (w.pump_on == w.blink_pump))
    else $error("pump drive disagrees with pump timer");

  a_pump_awake: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && w.pump_on |-> w.sleep_class == rpc_pkg::SLEEP_MIN &&
                                !w.blink_idle && !w.blink_yield)
    else $error("sleep or idle blink while pumping");

  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> w.loop_mode != 2'd3 && w.sleep_class != 2'd3 && w.pad == 3'd0)
    else $error("undefined code in result word");

endmodule

bind recirc_pump_controller rpc_checker u_rpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- bench/recirc_pump_controller_test.sv -----
`timescale 1ns / 1ps
// recirc_pump_controller_test: self-checking bench for the recirculation pump controller.
// Feeds rounds and register writes, predicts or types each result word and compares it.
// Depends on rpc_pkg and the recirc_pump_controller RTL.

module recirc_pump_controller_test;

  localparam int NUM_SENSORS   = 4;
  localparam int ADC_FULL      = 4095;
  localparam int FLOW_IN_USE   = ADC_FULL * 90 / 100;
  localparam int FLOW_VERANDA  = ADC_FULL * 50 / 100;
  localparam int MSEC          = 1000;
  localparam int HOT_LIMIT     = 1000;
  localparam int REFRESH_S     = 180;
  localparam int INIT_YIELD_S  = 10;
  localparam int BLINK_S       = 5;
  localparam int PHASE_ROUNDS  = 460;

  typedef struct packed {
    logic [15:0] temp_d;
    logic [15:0] temp_c;
    logic [15:0] temp_b;
    logic [15:0] temp_a;
    logic [2:0]  sensor_count;
    logic [11:0] flow_level;
    logic [31:0] clock_msec;
  } round_t;

  typedef struct packed {
    round_t             rnd;
    logic               typed;
    rpc_pkg::out_word_t word;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_wdata = '0;

  recirc_pump_controller #(
    .SENSORS        (NUM_SENSORS),
    .ADC_FULL_SCALE (ADC_FULL)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor: register copies and controller state, at their reset values
  logic [10:0] pump_limit  = 11'd180;
  logic [8:0]  valve_limit = 9'd20;
  logic [10:0] yield_limit = 11'd300;
  logic [15:0] read_period = 16'd10;
  logic [9:0]  stop_tenths = 10'd420;
  logic [31:0] seen_msec   = '0;
  logic [15:0] pump_left   = 16'd10;
  logic [15:0] valve_left  = '0;
  logic [15:0] yield_left  = '0;
  logic [15:0] read_left   = '0;
  logic [15:0] blink_left  = '0;
  logic [2:0]  ctl_flags   = 3'b100;
  logic        running     = 1'b0;
  logic signed [15:0] held_temp [NUM_SENSORS] = '{default: '0};
  logic [2:0]  held_count  = '0;

  rpc_pkg::out_word_t expected_q[$];
  rpc_pkg::out_word_t want;
  int        mismatches = 0;
  int        results_seen = 0;
  int        send_idle_pct = 18;
  int        recv_idle_pct = 81;
  logic [31:0] stim_msec = '0;
  dir_row_t  dir_rows[$];

  function automatic round_t mk_round(input logic [31:0] ms, input logic [11:0] flow,
                                      input logic [2:0] cnt, input logic [15:0] ta,
                                      input logic [15:0] tb, input logic [15:0] tc,
                                      input logic [15:0] td);
    round_t r;
    r.clock_msec   = ms;
    r.flow_level   = flow;
    r.sensor_count = cnt;
    r.temp_a = ta;
    r.temp_b = tb;
    r.temp_c = tc;
    r.temp_d = td;
    return r;
  endfunction

  function automatic rpc_pkg::out_word_t mk_word(input logic pump_on,
                                                 input rpc_pkg::loop_mode_t mode,
                                                 input logic bp, input logic bv,
                                                 input logic byl, input logic bi,
                                                 input rpc_pkg::sleep_t slp,
                                                 input logic [2:0] fl,
                                                 input logic [15:0] secs,
                                                 input logic lat);
    rpc_pkg::out_word_t w;
    w = '0;
    w.pump_on           = pump_on;
    w.loop_mode         = mode;
    w.blink_pump        = bp;
    w.blink_valve       = bv;
    w.blink_yield       = byl;
    w.blink_idle        = bi;
    w.sleep_class       = slp;
    w.status_flags      = fl;
    w.pump_seconds_left = secs;
    w.temps_latched     = lat;
    return w;
  endfunction

  function automatic logic [15:0] count_down(input logic [15:0] v, input logic [15:0] by);
    return (v > by) ? v - by : '0;
  endfunction

  function automatic rpc_pkg::out_word_t predict_round(input round_t r);
    logic [31:0] diff;
    logic [15:0] secs;
    logic [15:0] t_in [4];
    int n;
    int t;
    logic latched, use_any, use_ver, hold, bp, bv, b_yield, b_idle;
    rpc_pkg::loop_mode_t mode;
    rpc_pkg::sleep_t slp;
    diff = r.clock_msec - seen_msec;
    secs = diff[15:0] / 16'(MSEC);
    latched = 1'b0;
    hold    = 1'b0;
    b_yield = 1'b0;
    b_idle  = 1'b0;
    if (secs != 0) begin
      seen_msec  = r.clock_msec;
      pump_left  = count_down(pump_left, secs);
      valve_left = count_down(valve_left, secs);
      yield_left = count_down(yield_left, secs);
      read_left  = count_down(read_left, secs);
      blink_left = count_down(blink_left, secs);
    end
    if (read_period != 0 && read_left == 0) begin
      read_left = read_period;
      n = (int'(r.sensor_count) > NUM_SENSORS) ? NUM_SENSORS : int'(r.sensor_count);
      if (n > 4) n = 4;
      t_in = '{r.temp_a, r.temp_b, r.temp_c, r.temp_d};
      for (int i = 0; i < n; i++) held_temp[i] = t_in[i];
      held_count = 3'(n);
      latched = 1'b1;
    end
    use_any = int'(r.flow_level) <= FLOW_IN_USE;
    use_ver = use_any && int'(r.flow_level) < FLOW_VERANDA;
    if (use_ver) ctl_flags[rpc_pkg::FLAG_FULL] = 1'b1;
    if (pump_left == 0 && !ctl_flags[rpc_pkg::FLAG_FIRST_RUN] &&
        !ctl_flags[rpc_pkg::FLAG_HOLDOFF] && use_any)
      pump_left = 16'(pump_limit);
    // cutoff: one cool sensor keeps the pump on
    if (read_period != 0 && stop_tenths != 0 && pump_left != 0) begin
      for (int i = 0; i < int'(held_count) && i < NUM_SENSORS; i++) begin
        t = held_temp[i];
        if (t < HOT_LIMIT && t < int'(stop_tenths)) hold = 1'b1;
      end
      if (!hold) pump_left = '0;
    end
    bp = pump_left != 0;
    bv = valve_left != 0;
    if (valve_left == 0) mode = rpc_pkg::MODE_IDLE;
    else if (ctl_flags[rpc_pkg::FLAG_FULL]) mode = rpc_pkg::MODE_FULL;
    else mode = rpc_pkg::MODE_NORMAL;
    if (pump_left != 0) begin
      if (!running) begin
        running = 1'b1;
        ctl_flags[rpc_pkg::FLAG_HOLDOFF] = 1'b1;
        yield_left = 16'(yield_limit);
      end
      slp = rpc_pkg::SLEEP_MIN;
    end else if (running) begin
      running = 1'b0;
      ctl_flags[rpc_pkg::FLAG_FULL] = 1'b0;
      valve_left = 16'(valve_limit);
      ctl_flags[rpc_pkg::FLAG_HOLDOFF] = 1'b1;
      yield_left = 16'(yield_limit);
      if (ctl_flags[rpc_pkg::FLAG_FIRST_RUN]) begin
        ctl_flags[rpc_pkg::FLAG_FIRST_RUN] = 1'b0;
        yield_left = 16'(INIT_YIELD_S);
      end
      slp = rpc_pkg::SLEEP_MIN;
    end else begin
      if (yield_left == 0) ctl_flags[rpc_pkg::FLAG_HOLDOFF] = 1'b0;
      if (ctl_flags[rpc_pkg::FLAG_HOLDOFF]) begin
        b_yield = 1'b1;
        if (yield_left < 16'(yield_limit) &&
            int'(yield_left) > int'(yield_limit) - REFRESH_S && use_any)
          yield_left = 16'(yield_limit);
        slp = rpc_pkg::SLEEP_MID;
      end else begin
        if (blink_left == 0) begin
          b_idle = 1'b1;
          blink_left = 16'(BLINK_S);
        end
        slp = rpc_pkg::SLEEP_MAX;
      end
    end
    return mk_word(running, mode, bp, bv, b_yield, b_idle, slp, ctl_flags, pump_left,
                   latched);
  endfunction

  function automatic logic [15:0] random_temp(input logic hot);
    int sel;
    sel = $urandom_range(0, 99);
    if (hot) begin
      if (sel < 70) return 16'(int'(stop_tenths) + $urandom_range(0, 400));
      return 16'($urandom_range(HOT_LIMIT, HOT_LIMIT + 200));
    end
    if (sel < 20) return 16'($urandom());
    if (sel < 70) return 16'(int'(stop_tenths) + $urandom_range(0, 60) - 30);
    return 16'($urandom_range(HOT_LIMIT - 100, HOT_LIMIT + 100));
  endfunction

  function automatic round_t random_round();
    round_t r;
    int sel;
    logic hot;
    sel = $urandom_range(0, 99);
    if (sel < 45) stim_msec = stim_msec + $urandom_range(0, 1999);
    else if (sel < 80) stim_msec = stim_msec + $urandom_range(2000, 15000);
    else if (sel < 95) stim_msec = stim_msec + $urandom_range(15000, 65535);
    else stim_msec = $urandom();
    r.clock_msec = stim_msec;
    sel = $urandom_range(0, 99);
    if (sel < 40) r.flow_level = 12'($urandom_range(FLOW_IN_USE + 1, ADC_FULL));
    else if (sel < 65) r.flow_level = 12'($urandom_range(FLOW_VERANDA, FLOW_IN_USE));
    else r.flow_level = 12'($urandom_range(0, FLOW_VERANDA - 1));
    sel = $urandom_range(0, 99);
    if (sel < 10) r.sensor_count = 3'd0;
    else if (sel < 85) r.sensor_count = 3'($urandom_range(1, 4));
    else r.sensor_count = 3'($urandom_range(5, 7));
    hot = $urandom_range(0, 99) < 40;
    r.temp_a = random_temp(hot);
    r.temp_b = random_temp(hot);
    r.temp_c = random_temp(hot);
    r.temp_d = random_temp(hot);
    return r;
  endfunction

  task automatic send_round(input round_t r, input logic typed,
                            input rpc_pkg::out_word_t word);
    int gap;
    rpc_pkg::out_word_t pred;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = predict_round(r);
    expected_q.push_back(typed ? word : pred);
  endtask

  // sender holds off until every result word is back, then lets the pipe settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input rpc_pkg::reg_idx_t idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      rpc_pkg::REG_PUMP_TIMEOUT:  pump_limit  = value[10:0];
      rpc_pkg::REG_VALVE_TIMEOUT: valve_limit = value[8:0];
      rpc_pkg::REG_YIELD_TIMEOUT: yield_limit = value[10:0];
      rpc_pkg::REG_READ_INTERVAL: read_period = value;
      rpc_pkg::REG_STOP_TEMP:     stop_tenths = value[9:0];
      rpc_pkg::REG_IDLE_TIMEOUT:  ;  // idle timer never reaches the result word
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] pump_s, input logic [15:0] valve_s,
                            input logic [15:0] yield_s, input logic [15:0] read_s,
                            input logic [15:0] stop_t, input logic [15:0] idle_s);
    write_reg(rpc_pkg::REG_PUMP_TIMEOUT, pump_s);
    write_reg(rpc_pkg::REG_VALVE_TIMEOUT, valve_s);
    write_reg(rpc_pkg::REG_YIELD_TIMEOUT, yield_s);
    write_reg(rpc_pkg::REG_READ_INTERVAL, read_s);
    write_reg(rpc_pkg::REG_STOP_TEMP, stop_t);
    write_reg(rpc_pkg::REG_IDLE_TIMEOUT, idle_s);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: no word expected, got %h", results_seen, out_tdata);
      end else begin
        want = expected_q.pop_front();
        if (rpc_pkg::out_word_t'(out_tdata) !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected %p, got %p", results_seen, want,
                     rpc_pkg::out_word_t'(out_tdata));
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("** recirc_pump_controller: FAILED **");
    $finish;
  end

  initial begin
    dir_rows = '{
      '{mk_round(32'd0, 12'd4095, 3'd4, 16'd200, 16'd210, 16'd220, 16'd230), 1'b1,
        mk_word(1'b1, rpc_pkg::MODE_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, rpc_pkg::SLEEP_MIN,
                3'b110, 16'd10, 1'b1)},
      '{mk_round(32'd999, 12'd4095, 3'd4, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk_round(32'd1000, 12'd4095, 3'd4, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      // initial run ends: short yield, initial flag cleared, veranda flag dropped
      '{mk_round(32'd11000, 12'd0, 3'd4, 16'd500, 16'd500, 16'd500, 16'd500), 1'b1,
        mk_word(1'b0, rpc_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, rpc_pkg::SLEEP_MIN,
                3'b010, 16'd0, 1'b1)},
      '{mk_round(32'd12000, 12'd2046, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk_round(32'd12999, 12'd2047, 3'd5, 16'd1, 16'd2, 16'd3, 16'd4), 1'b0, '0},
      '{mk_round(32'd22000, 12'd3685, 3'd7, 16'h8000, 16'h7fff, 16'd999, 16'd1000),
        1'b0, '0},
      '{mk_round(32'd22500, 12'd3686, 3'd6, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk_round(32'd23000, 12'd3685, 3'd3, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      // latch with no sensors: cutoff stops the pump
      '{mk_round(32'd33000, 12'd4095, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk_round(32'd34000, 12'd1000, 3'd1, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk_round(32'hffff_ffff, 12'd4095, 3'd2, 16'hffff, 16'h8000, 16'd0, 16'd0),
        1'b0, '0},
      '{mk_round(32'd999, 12'd0, 3'd4, 16'd100, 16'd100, 16'd100, 16'd100), 1'b0, '0},
      '{mk_round(32'h0001_03e7, 12'd0, 3'd4, 16'd100, 16'd100, 16'd100, 16'd100),
        1'b0, '0},
      '{mk_round(32'h8000_0000, 12'd2046, 3'd4, 16'd419, 16'd420, 16'd421, 16'hffff),
        1'b0, '0},
      '{mk_round(32'h8000_03e8, 12'd3685, 3'd4, 16'd421, 16'd421, 16'd421, 16'd421),
        1'b0, '0},
      '{mk_round(32'h8000_2710, 12'd0, 3'd4, 16'd999, 16'd999, 16'd999, 16'd999),
        1'b0, '0},
      '{mk_round(32'h8000_ea60, 12'd4095, 3'd1, 16'd1000, 16'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk_round(32'h8001_d4c0, 12'd4095, 3'd4, 16'd600, 16'd700, 16'd800, 16'd900),
        1'b0, '0},
      '{mk_round(32'h8002_bf20, 12'd2000, 3'd4, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff),
        1'b0, '0},
      '{mk_round(32'h8003_a980, 12'd4095, 3'd4, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_round(dir_rows[i].rnd, dir_rows[i].typed, dir_rows[i].word);
      stim_msec = dir_rows[i].rnd.clock_msec;
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 81;
          set_config(16'd10, 16'd8, 16'd30, 16'd1, 16'd600, 16'd600);
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 18;
          set_config(16'd1200, 16'd300, 16'd1200, 16'd65535, 16'd0, 16'd36000);
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          set_config(16'd60, 16'd20, 16'd200, 16'd0, 16'd420, 16'd0);
        end
        default: begin
          // in-range values, with junk above the width of the narrower registers
          set_config(16'($urandom_range(10, 300) | ($urandom_range(0, 31) << 11)),
                     16'($urandom_range(8, 60) | ($urandom_range(0, 127) << 9)),
                     16'($urandom_range(30, 600) | ($urandom_range(0, 31) << 11)),
                     16'($urandom_range(0, 40)),
                     16'($urandom_range(0, 600) | ($urandom_range(0, 63) << 10)),
                     16'($urandom_range(0, 65535)));
        end
      endcase
      for (int k = 0; k < PHASE_ROUNDS; k++) begin
        if (ph == 0 && k == PHASE_ROUNDS / 2) drain_results();
        send_round(random_round(), 1'b0, '0);
      end
    end

    drain_results();
    if (mismatches == 0 && expected_q.size() == 0)
      $display("** recirc_pump_controller: PASSED **");
    else
      $display("** recirc_pump_controller: FAILED **");
    $finish;
  end

endmodule
